// ----- rtl/sphere_mesh_generator_defines.svh -----
// Assertion macros shared by the sphere mesh generator checker.
// Depends on nothing; included by files that assert.
`ifndef SPHERE_MESH_GENERATOR_DEFINES_SVH
`define SPHERE_MESH_GENERATOR_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define SMG_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define SMG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/smg_pkg.sv -----
// Shared types and constants of the sphere mesh generator.
// Depends on nothing.
`default_nettype none
package smg_pkg;
  localparam int unsigned ANG_W = 32;
  localparam int unsigned Q_W   = 32;   // signed Q30 with headroom
  localparam logic [31:0] PI_Q30 = 32'hC90FDAA2;
  localparam logic [30:0] ONE_Q30 = 31'h40000000;

  typedef enum logic {
    OP_VERTEX = 1'b0,
    OP_QUAD   = 1'b1
  } op_e;

  typedef struct packed {
    logic        bad;
    logic [15:0] idx;
  } meta_t;
endpackage
`default_nettype wire

// ----- rtl/smg_phase_div.sv -----
// Pipelined restoring divider producing floor((n << k) / d) phases.
// Depends on nothing; one quotient bit per stage.
`default_nettype none
module smg_phase_div #(
  parameter int unsigned NumW = 8,
  parameter int unsigned DenW = 9,
  parameter int unsigned QW   = 32
) (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic      [QW-1:0]   quo_o
);
  // Dividend is num << QW (the low QW bits of the quotient are then taken).
  localparam int unsigned RW = DenW + 1;
  localparam int unsigned NB = NumW + QW;

  logic [RW-1:0]   rem_q  [NB+1];
  logic [NB-1:0]   dvd_q  [NB+1];
  logic [DenW-1:0] den_q  [NB+1];

  always_comb begin
    rem_q[0] = '0;
    dvd_q[0] = {num_i, {QW{1'b0}}};
    den_q[0] = den_i;
  end

  for (genvar s = 0; s < NB; s++) begin : g_stage
    logic [RW:0]   tr;
    logic [RW:0]   dif;
    logic [RW-1:0] rem_d;
    logic [NB-1:0] dvd_d;
    always_comb begin
      tr  = {rem_q[s], dvd_q[s][NB-1]};
      dif = tr - {2'b00, den_q[s]};
      if (!dif[RW]) begin
        rem_d = dif[RW-1:0];
        dvd_d = {dvd_q[s][NB-2:0], 1'b1};
      end else begin
        rem_d = tr[RW-1:0];
        dvd_d = {dvd_q[s][NB-2:0], 1'b0};
      end
    end
    if (s % 4 == 3) begin : g_reg
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s+1] <= rem_d;
          dvd_q[s+1] <= dvd_d;
          den_q[s+1] <= den_q[s];
        end
      end
    end else begin : g_comb
      always_comb begin
        rem_q[s+1] = rem_d;
        dvd_q[s+1] = dvd_d;
        den_q[s+1] = den_q[s];
      end
    end
  end

  assign quo_o = dvd_q[NB][QW-1:0];
endmodule
`default_nettype wire

// ----- rtl/smg_delay.sv -----
// Enable-gated delay line used to align side data with the datapath.
// Depends on nothing.
`default_nettype none
module smg_delay #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);
  logic [W-1:0] tap_q [N+1];
  assign tap_q[0] = d_i;
  for (genvar k = 0; k < N; k++) begin : g_tap
    always_ff @(posedge clk_i) begin
      if (en_i) tap_q[k+1] <= tap_q[k];
    end
  end
  assign q_o = tap_q[N];
endmodule
`default_nettype wire

// ----- rtl/smg_sincos.sv -----
// Pipelined polynomial sine and cosine of a 32-bit turn fraction, Q30 out.
// Depends on smg_pkg and smg_delay.
`default_nettype none
module smg_sincos (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [31:0]       phase_i,
  output logic signed [31:0]     sin_o,
  output logic signed [31:0]     cos_o
);
  localparam int unsigned NS = 11;   // horner stages, registered each

  // Stage A: quadrant reduce and scale to radians.
  logic [29:0] r;
  logic [1:0]  q;
  logic        neg;
  logic [63:0] xm;
  logic [31:0] x_q;
  logic [1:0]  q_q;
  logic        neg_q;
  always_comb begin
    r   = phase_i[29:0];
    q   = phase_i[31:30];
    neg = 1'b0;
    if (phase_i[29]) begin
      r   = 30'(31'h40000000 - {1'b0, phase_i[29:0]});
      neg = 1'b1;
      q   = q + 2'd1;
    end
    xm = {34'd0, r} * {32'd0, smg_pkg::PI_Q30};
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= xm[62:31];
      q_q   <= q;
      neg_q <= neg;
    end
  end

  // Stage B: x squared.
  logic [63:0] x2m;
  logic [31:0] x2_q, xb_q;
  logic [1:0]  qb_q;
  logic        negb_q;
  assign x2m = {32'd0, x_q} * {32'd0, x_q};
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x2_q <= x2m[61:30];
      xb_q <= x_q;
      qb_q <= q_q;
      negb_q <= neg_q;
    end
  end

  // Horner chains: sin uses 72,42,20,6 and cos 90,56,30,12,2.
  // Both chains advance together; a step is x2 times p, then a divide.
  logic [31:0] ps_q [NS+1];
  logic [31:0] pc_q [NS+1];
  logic [31:0] x2p_q [NS+1];
  logic [31:0] xp_q [NS+1];
  // Each step is split in two stages: multiply, then constant divide.
  logic [31:0] ms_q [NS+1];
  logic [31:0] mc_q [NS+1];
  assign ps_q[0] = 32'(smg_pkg::ONE_Q30);
  assign pc_q[0] = 32'(smg_pkg::ONE_Q30);
  assign x2p_q[0] = x2_q;
  assign xp_q[0] = xb_q;
  assign ms_q[0] = '0;
  assign mc_q[0] = '0;

  // Floor division by the Horner constants as a reciprocal multiplication.
  // The reciprocals are rounded up, which is exact for inputs below 2^30.
  function automatic logic [31:0] sdiv(input logic [31:0] v, input int k);
    logic [63:0] p;
    case (k)
      0: p = ({32'd0, v} * 64'd1908874354) >> 37;
      1: p = ({32'd0, v} * 64'd1636178018) >> 36;
      2: p = ({32'd0, v} * 64'd1717986919) >> 35;
      3: p = ({32'd0, v} * 64'd1431655766) >> 33;
      default: p = {32'd0, v};
    endcase
    return p[31:0];
  endfunction
  function automatic logic [31:0] cdiv(input logic [31:0] v, input int k);
    logic [63:0] p;
    case (k)
      0: p = ({32'd0, v} * 64'd1527099484) >> 37;
      1: p = ({32'd0, v} * 64'd1227133514) >> 36;
      2: p = ({32'd0, v} * 64'd1145324613) >> 35;
      3: p = ({32'd0, v} * 64'd1431655766) >> 34;
      4: p = {33'd0, v[31:1]};
      default: p = {32'd0, v};
    endcase
    return p[31:0];
  endfunction

  // Even stages divide and subtract, odd stages multiply.
  for (genvar k = 0; k < NS; k++) begin : g_h
    logic [63:0] mps, mpc;
    logic [31:0] ps_d, pc_d, ms_d, mc_d;
    always_comb begin
      mps = {32'd0, x2p_q[k]} * {32'd0, ps_q[k]};
      mpc = {32'd0, x2p_q[k]} * {32'd0, pc_q[k]};
      ps_d = ps_q[k];
      pc_d = pc_q[k];
      ms_d = ms_q[k];
      mc_d = mc_q[k];
      if (k == 0) begin
        ps_d = 32'(smg_pkg::ONE_Q30) - sdiv(x2p_q[k], 0);
        pc_d = 32'(smg_pkg::ONE_Q30) - cdiv(x2p_q[k], 0);
      end else if (k % 2 == 1) begin
        ms_d = mps[61:30];
        mc_d = mpc[61:30];
      end else begin
        if (k / 2 <= 3) ps_d = 32'(smg_pkg::ONE_Q30) - sdiv(ms_q[k], k / 2);
        if (k / 2 <= 4) pc_d = 32'(smg_pkg::ONE_Q30) - cdiv(mc_q[k], k / 2);
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ps_q[k+1]  <= ps_d;
        pc_q[k+1]  <= pc_d;
        ms_q[k+1]  <= ms_d;
        mc_q[k+1]  <= mc_d;
        x2p_q[k+1] <= x2p_q[k];
        xp_q[k+1]  <= xp_q[k];
      end
    end
  end

  // After NS stages pc holds the cosine magnitude and ps the last sine
  // factor; the sine is x * p, taken below.
  // k=0 divides by 72/90, k=2 by 42/56, k=4 by 20/30, k=6 by 6/12,
  // k=8 finishes the cosine by 2, and k=10 holds.
  logic [63:0] sm;
  logic [31:0] s_q, c_q;
  assign sm = {32'd0, xp_q[NS]} * {32'd0, ps_q[NS]};
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= sm[61:30];
      c_q <= pc_q[NS];
    end
  end

  logic [1:0] qd;
  logic       negd;
  smg_delay #(.W(3), .N(NS + 1)) u_qd (
    .clk_i(clk_i), .en_i(en_i), .d_i({qb_q, negb_q}), .q_o({qd, negd})
  );

  logic signed [31:0] sa, ca;
  always_comb begin
    sa = negd ? -$signed(s_q) : $signed(s_q);
    ca = $signed(c_q);
    case (qd)
      2'd0: begin sin_o = sa; cos_o = ca; end
      2'd1: begin sin_o = ca; cos_o = -sa; end
      2'd2: begin sin_o = -sa; cos_o = -ca; end
      default: begin sin_o = -ca; cos_o = sa; end
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/sphere_mesh_generator.sv -----
// UV sphere mesh generator: vertex positions and quad index lists.
// Depends on smg_pkg, smg_phase_div, smg_sincos and smg_delay.
//
// A request transfer happens whenever start is high and busy is low. A vertex
// request enters a fully pipelined datapath (phase divider, polynomial
// sine/cosine, products, rounding), and its single result leaves through
// the registers of the phase divider, then of the sine and cosine, then of
// the products and the rounding. Vertex requests can be issued every cycle
// while busy is low. A quad request produces six index transfers on
// consecutive cycles; once it is taken, busy stays high until the sixth index
// is shown. A quad waits for earlier vertex results to drain, and busy stays
// high while it waits, so results leave in request order. Error results are
// one transfer that travels through the vertex pipeline like a vertex result.
// The receiver cannot stall: each result is shown for exactly one cycle with
// valid_o high.
`default_nettype none
module sphere_mesh_generator #(
  parameter int unsigned MAX_STEPS = 256,
  parameter int unsigned FRAC_BITS = 14
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        op_i,
  input  wire logic [7:0]  row_i,
  input  wire logic [7:0]  col_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [8:0]  cfg_data_i,
  output logic             valid_o,
  output logic [15:0]      x_pos_o,
  output logic [15:0]      y_pos_o,
  output logic [15:0]      z_pos_o,
  output logic [15:0]      vertex_index_o,
  output logic             last_o,
  output logic             error_o
);
  localparam int unsigned DIV_LAT = (8 + 32) / 4;
  localparam int unsigned SC_LAT  = 14;
  localparam int unsigned LAT     = DIV_LAT + SC_LAT + 2;

  logic [8:0] ring_q, seg_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q <= 9'd16;
      seg_q  <= 9'd16;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == 1'b0) ring_q <= cfg_data_i;
      else seg_q <= cfg_data_i;
    end
  end

  logic acc, bad_cnt, v_bad, q_bad;
  assign acc = start && !busy;
  assign bad_cnt = (ring_q < 9'd2) || (seg_q < 9'd2) ||
                   ({23'd0, ring_q} > 32'(MAX_STEPS)) ||
                   ({23'd0, seg_q} > 32'(MAX_STEPS));
  assign v_bad = bad_cnt || ({1'b0, row_i} >= ring_q) || ({1'b0, col_i} >= seg_q);
  assign q_bad = bad_cnt || ({1'b0, row_i} + 9'd1 >= ring_q) ||
                 ({1'b0, col_i} + 9'd1 >= seg_q);

  // Vertex index products.
  logic [16:0] i0, i1;
  assign i0 = 17'(row_i * seg_q) + 17'(col_i);
  assign i1 = i0 + 17'(seg_q);

  // Vertex path (always enabled; no stalls).
  logic [31:0] lat_ph, lon_ph;
  logic [31:0] lat_full;
  smg_phase_div #(.NumW(8), .DenW(9), .QW(32)) u_lat (
    .clk_i(clk_i), .en_i(1'b1), .num_i(row_i), .den_i(ring_q), .quo_o(lat_full)
  );
  assign lat_ph = {1'b0, lat_full[31:1]};
  smg_phase_div #(.NumW(8), .DenW(9), .QW(32)) u_lon (
    .clk_i(clk_i), .en_i(1'b1), .num_i(col_i), .den_i(seg_q), .quo_o(lon_ph)
  );

  logic signed [31:0] slat, clat, slon, clon;
  smg_sincos u_sc_lat (.clk_i(clk_i), .en_i(1'b1), .phase_i(lat_ph),
                       .sin_o(slat), .cos_o(clat));
  smg_sincos u_sc_lon (.clk_i(clk_i), .en_i(1'b1), .phase_i(lon_ph),
                       .sin_o(slon), .cos_o(clon));

  // Products, truncated toward zero.
  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic        n;
    logic [31:0] ma, mb;
    logic [63:0] p;
    n  = a[31] ^ b[31];
    ma = a[31] ? 32'(-a) : 32'(a);
    mb = b[31] ? 32'(-b) : 32'(b);
    p  = {32'd0, ma} * {32'd0, mb};
    return n ? -$signed(p[61:30]) : $signed(p[61:30]);
  endfunction
  // With 30 fraction bits out there is nothing to round away.
  function automatic logic [15:0] to_out(input logic signed [31:0] v);
    logic        n;
    logic [31:0] m;
    n = v[31];
    m = n ? 32'(-v) : 32'(v);
    if (FRAC_BITS < 30) m = (m + (32'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    if (n) begin
      if (m > 32'd32768) m = 32'd32768;
      return 16'(-m);
    end
    if (m > 32'd32767) m = 32'd32767;
    return m[15:0];
  endfunction

  logic signed [31:0] px_q, pz_q, py_q;
  logic [15:0] ox_q, oy_q, oz_q;
  always_ff @(posedge clk_i) begin
    px_q <= mulq(slat, clon);
    pz_q <= mulq(slat, slon);
    py_q <= clat;
    ox_q <= to_out(px_q);
    oy_q <= to_out(py_q);
    oz_q <= to_out(pz_q);
  end

  // Tag line: valid, error, index. Error requests bypass nothing; they
  // travel with the same latency to keep order.
  logic        vtag_v;
  logic        vtag_e;
  logic [15:0] vtag_i;
  logic        vld_q [LAT+1];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= LAT; k++) vld_q[k] <= 1'b0;
    end else begin
      for (int k = 1; k <= LAT; k++) vld_q[k] <= vld_q[k-1];
    end
  end
  assign vld_q[0] = acc && (op_i == smg_pkg::OP_VERTEX || q_bad);
  smg_delay #(.W(17), .N(LAT)) u_tag (
    .clk_i(clk_i), .en_i(1'b1),
    .d_i({(op_i == smg_pkg::OP_VERTEX) ? v_bad : 1'b1, i0[15:0]}),
    .q_o({vtag_e, vtag_i})
  );
  assign vtag_v = vld_q[LAT];

  // Pipeline occupancy, used to hold quads until vertex results drain.
  logic inflight;
  always_comb begin
    inflight = 1'b0;
    for (int k = 1; k <= LAT; k++) inflight = inflight | vld_q[k];
  end

  // Quad sequencer.
  logic [2:0]  qcnt_q;
  logic [15:0] qi0_q, qi1_q;
  logic        qpend_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qcnt_q <= '0;
      qpend_q <= 1'b0;
    end else if (acc && op_i == smg_pkg::OP_QUAD && !q_bad) begin
      qpend_q <= 1'b1;
      qcnt_q  <= '0;
    end else if (qpend_q && !inflight) begin
      if (qcnt_q == 3'd5) qpend_q <= 1'b0;
      qcnt_q <= qcnt_q + 3'd1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (acc) begin
      qi0_q <= i0[15:0];
      qi1_q <= i1[15:0];
    end
  end

  // The next request may be taken while the sixth index is shown.
  logic qv;
  assign qv = qpend_q && !inflight;
  assign busy = qpend_q && !(qv && qcnt_q == 3'd5);

  always_comb begin
    valid_o = 1'b0; x_pos_o = '0; y_pos_o = '0; z_pos_o = '0;
    vertex_index_o = '0; last_o = 1'b0; error_o = 1'b0;
    if (vtag_v) begin
      valid_o = 1'b1; last_o = 1'b1; error_o = vtag_e;
      if (!vtag_e) begin
        x_pos_o = ox_q; y_pos_o = oy_q; z_pos_o = oz_q; vertex_index_o = vtag_i;
      end
    end else if (qv) begin
      valid_o = 1'b1;
      case (qcnt_q)
        3'd0: vertex_index_o = qi0_q;
        3'd1: vertex_index_o = qi1_q;
        3'd2, 3'd3: vertex_index_o = qi1_q + 16'd1;
        3'd4: vertex_index_o = qi0_q + 16'd1;
        default: begin vertex_index_o = qi0_q; last_o = 1'b1; end
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/smg_checker.sv -----
// Port-level checker for the sphere mesh generator, bound to the top level.
// Depends on sphere_mesh_generator_defines.svh.
`include "sphere_mesh_generator_defines.svh"
`default_nettype none
module smg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        busy,
  input wire logic        valid_o,
  input wire logic        last_o,
  input wire logic        error_o,
  input wire logic [15:0] x_pos_o,
  input wire logic [15:0] vertex_index_o
);
  `SMG_ASSERT_IMPL(a_err_last, clk_i, rst_ni, valid_o && error_o, last_o)
  `SMG_ASSERT_IMPL(a_err_zero, clk_i, rst_ni, valid_o && error_o,
                   x_pos_o == 16'd0 && vertex_index_o == 16'd0)
  `SMG_ASSERT_IMPL(a_quad_busy, clk_i, rst_ni, valid_o && !last_o, busy)
  `SMG_ASSERT_NEXT(a_quad_run, clk_i, rst_ni, valid_o && !last_o, valid_o && !error_o)
endmodule
bind sphere_mesh_generator smg_checker u_smg_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .busy(busy), .valid_o(valid_o),
  .last_o(last_o), .error_o(error_o), .x_pos_o(x_pos_o),
  .vertex_index_o(vertex_index_o)
);
`default_nettype wire
